@@ hdl/usc_pkg.sv @@
// ----------------------------------------------------------------------------
// usc_pkg
// Shared types and constants for the unix seconds to calendar converter.
// ----------------------------------------------------------------------------
package usc_pkg;

    localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
    localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SEC_PER_MIN  = 6'd60;

    // reciprocals for the pre-shifted divisors 675, 225 and 15
    localparam logic [25:0] DAY_RECIP  = 26'd50903317;
    localparam logic [13:0] HOUR_RECIP = 14'd9321;
    localparam logic [10:0] MIN_RECIP  = 11'd1093;

    localparam logic [11:0] EPOCH_YEAR     = 12'd1970;
    localparam logic [1:0]  EPOCH_MOD4     = 2'd2;
    localparam logic [6:0]  EPOCH_MOD100   = 7'd70;
    localparam logic [8:0]  EPOCH_MOD400   = 9'd370;
    localparam logic [8:0]  DAYS_LEAP      = 9'd366;
    localparam logic [8:0]  DAYS_COMMON    = 9'd365;
    localparam logic [4:0]  FEB_LEAP_DAYS  = 5'd29;
    localparam logic [3:0]  MONTH_FEB      = 4'd1;
    localparam logic [3:0]  MONTH_DEC      = 4'd11;
    localparam logic [3:0]  MONTH_COUNT    = 4'd12;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic load_in;
        logic div_day;
        logic rem_day;
        logic div_hour;
        logic rem_hour;
        logic div_min;
        logic rem_min;
        logic year_step;
        logic month_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic year_done;
        logic month_done;
    } status_t;

    typedef struct packed {
        logic [4:0]  day_of_month;
        logic [3:0]  month;
        logic [11:0] year;
        logic [2:0]  weekday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } result_t;

endpackage

@@ hdl/unix_seconds_to_calendar.sv @@
// sequence: load, then divide and remainder for days, hours and minutes, then the
//   year walk and the month walk, before the result loads
// throughput: one word at a time; the next word is taken in the cycle after the result loads
// the finished result waits in an output register without blocking input
// reset: aresetn synchronous active low, clears the controller and output valid
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar
// Converts unix seconds to second, minute, hour, weekday, year, month, day.
// ----------------------------------------------------------------------------
module unix_seconds_to_calendar (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // unix_seconds[31:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // second[5:0], minute[11:6], hour[16:12], weekday[19:17], year[31:20],
    // month[35:32], day_of_month[40:36], zero[47:41]
    output logic [47:0] m_tdata
);

    usc_pkg::cmd_t    cmd;
    usc_pkg::status_t status;
    usc_pkg::result_t result;

    usc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    usc_dpath u_dpath (
        .aclk         (aclk),
        .unix_seconds (s_tdata),
        .cmd          (cmd),
        .status       (status),
        .result       (result)
    );

    assign m_tdata = {7'b0, result};

endmodule

@@ hdl/usc_dpath.sv @@
// ----------------------------------------------------------------------------
// usc_dpath
// Datapath: reciprocal-multiply dividers, year and month walkers, result word.
// ----------------------------------------------------------------------------
module usc_dpath (
    input  logic              aclk,
    input  logic [31:0]       unix_seconds,
    input  usc_pkg::cmd_t     cmd,
    output usc_pkg::status_t  status,
    output usc_pkg::result_t  result
);

    logic [31:0] t_reg, t_next;
    logic [15:0] day_reg, day_next;
    logic [16:0] sod_reg, sod_next;
    logic [11:0] soh_reg, soh_next;
    logic [5:0]  min_reg, min_next;
    logic [5:0]  sec_reg, sec_next;
    logic [11:0] year_reg, year_next;
    logic [1:0]  y4_reg, y4_next;
    logic [6:0]  y100_reg, y100_next;
    logic [8:0]  y400_reg, y400_next;
    logic [3:0]  mon_reg, mon_next;
    logic [4:0]  hour_reg, hour_next;
    logic [2:0]  wd_reg, wd_next;
    usc_pkg::result_t res_reg, res_next;

    logic [50:0] day_prod;
    logic [31:0] day_secs;
    logic [31:0] sod_full;
    logic [25:0] hour_prod;
    logic [16:0] hour_secs;
    logic [16:0] soh_full;
    logic [19:0] min_prod;
    logic [11:0] min_secs;
    logic [11:0] sec_full;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;

    // (days + 4) mod 7 + 1, octal digit folding since 8 is 1 mod 7
    function automatic logic [2:0] weekday_of(input logic [15:0] d);
        logic [5:0] s1;
        logic [3:0] s2;
        begin
            s1 = 6'({3'b0, d[2:0]}) + 6'({3'b0, d[5:3]}) + 6'({3'b0, d[8:6]})
               + 6'({3'b0, d[11:9]}) + 6'({3'b0, d[14:12]}) + 6'({5'b0, d[15]})
               + 6'd4;
            s2 = 4'({1'b0, s1[2:0]}) + 4'({1'b0, s1[5:3]});
            if (s2 >= 4'd7) begin
                s2 = s2 - 4'd7;
            end
            weekday_of = s2[2:0] + 3'd1;
        end
    endfunction

    // days = (t >> 7) / 675
    assign day_prod = 51'(t_reg[31:7]) * 51'(usc_pkg::DAY_RECIP);
    assign day_secs = 32'(day_reg) * 32'(usc_pkg::SEC_PER_DAY);
    assign sod_full = t_reg - day_secs;

    // hours = (sod >> 4) / 225
    assign hour_prod = 26'(sod_reg[16:4]) * 26'(usc_pkg::HOUR_RECIP);
    assign hour_secs = 17'(hour_reg) * 17'(usc_pkg::SEC_PER_HOUR);
    assign soh_full  = sod_reg - hour_secs;

    // minutes = (soh >> 2) / 15
    assign min_prod = 20'(soh_reg[11:2]) * 20'(usc_pkg::MIN_RECIP);
    assign min_secs = 12'(min_reg) * 12'(usc_pkg::SEC_PER_MIN);
    assign sec_full = soh_reg - min_secs;

    assign leap = (y4_reg == 2'd0) && ((y100_reg != 7'd0) || (y400_reg == 9'd0));
    assign ylen = leap ? usc_pkg::DAYS_LEAP : usc_pkg::DAYS_COMMON;

    always_comb begin
        if ((mon_reg == usc_pkg::MONTH_FEB) && leap) begin
            mlen = usc_pkg::FEB_LEAP_DAYS;
        end else if (mon_reg < usc_pkg::MONTH_COUNT) begin
            mlen = usc_pkg::MONTH_LEN[mon_reg];
        end else begin
            mlen = 5'd0;
        end
    end

    assign status.year_done  = (day_reg < {7'b0, ylen});
    assign status.month_done = (day_reg < {11'b0, mlen}) || (mon_reg == usc_pkg::MONTH_DEC);

    always_comb begin
        t_next    = t_reg;
        day_next  = day_reg;
        sod_next  = sod_reg;
        soh_next  = soh_reg;
        min_next  = min_reg;
        sec_next  = sec_reg;
        year_next = year_reg;
        y4_next   = y4_reg;
        y100_next = y100_reg;
        y400_next = y400_reg;
        mon_next  = mon_reg;
        hour_next = hour_reg;
        wd_next   = wd_reg;
        res_next  = res_reg;

        if (cmd.load_in) begin
            t_next = unix_seconds;
        end

        if (cmd.div_day) begin
            day_next = day_prod[50:35];
        end

        // seconds of day, weekday and walk start
        if (cmd.rem_day) begin
            sod_next  = sod_full[16:0];
            wd_next   = weekday_of(day_reg);
            year_next = usc_pkg::EPOCH_YEAR;
            y4_next   = usc_pkg::EPOCH_MOD4;
            y100_next = usc_pkg::EPOCH_MOD100;
            y400_next = usc_pkg::EPOCH_MOD400;
            mon_next  = 4'd0;
        end

        if (cmd.div_hour) begin
            hour_next = hour_prod[25:21];
        end

        if (cmd.rem_hour) begin
            soh_next = soh_full[11:0];
        end

        if (cmd.div_min) begin
            min_next = min_prod[19:14];
        end

        if (cmd.rem_min) begin
            sec_next = sec_full[5:0];
        end

        if (cmd.year_step) begin
            day_next  = day_reg - {7'b0, ylen};
            year_next = year_reg + 12'd1;
            y4_next   = y4_reg + 2'd1;
            y100_next = (y100_reg == 7'd99) ? 7'd0 : y100_reg + 7'd1;
            y400_next = (y400_reg == 9'd399) ? 9'd0 : y400_reg + 9'd1;
        end

        if (cmd.month_step) begin
            day_next = day_reg - {11'b0, mlen};
            mon_next = mon_reg + 4'd1;
        end

        if (cmd.load_out) begin
            res_next.second       = sec_reg;
            res_next.minute       = min_reg;
            res_next.hour         = hour_reg;
            res_next.weekday      = wd_reg;
            res_next.year         = year_reg;
            res_next.month        = mon_reg;
            res_next.day_of_month = day_reg[4:0] + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        t_reg    <= t_next;
        day_reg  <= day_next;
        sod_reg  <= sod_next;
        soh_reg  <= soh_next;
        min_reg  <= min_next;
        sec_reg  <= sec_next;
        year_reg <= year_next;
        y4_reg   <= y4_next;
        y100_reg <= y100_next;
        y400_reg <= y400_next;
        mon_reg  <= mon_next;
        hour_reg <= hour_next;
        wd_reg   <= wd_next;
        res_reg  <= res_next;
    end

    assign result = res_reg;

endmodule

@@ hdl/usc_ctrl.sv @@
// ----------------------------------------------------------------------------
// usc_ctrl
// Controller: sequences the divider, year walk and month walk per word.
// ----------------------------------------------------------------------------
module usc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  usc_pkg::status_t  status,
    output usc_pkg::cmd_t     cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DIV_DAY  = 4'd1;
    localparam logic [3:0] ST_REM_DAY  = 4'd2;
    localparam logic [3:0] ST_DIV_HOUR = 4'd3;
    localparam logic [3:0] ST_REM_HOUR = 4'd4;
    localparam logic [3:0] ST_DIV_MIN  = 4'd5;
    localparam logic [3:0] ST_REM_MIN  = 4'd6;
    localparam logic [3:0] ST_YEAR     = 4'd7;
    localparam logic [3:0] ST_MONTH    = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       valid_reg, valid_next;
    logic       out_free;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DIV_DAY;
                end
            end
            ST_DIV_DAY: begin
                cmd.div_day = 1'b1;
                state_next  = ST_REM_DAY;
            end
            ST_REM_DAY: begin
                cmd.rem_day = 1'b1;
                state_next  = ST_DIV_HOUR;
            end
            ST_DIV_HOUR: begin
                cmd.div_hour = 1'b1;
                state_next   = ST_REM_HOUR;
            end
            ST_REM_HOUR: begin
                cmd.rem_hour = 1'b1;
                state_next   = ST_DIV_MIN;
            end
            ST_DIV_MIN: begin
                cmd.div_min = 1'b1;
                state_next  = ST_REM_MIN;
            end
            ST_REM_MIN: begin
                cmd.rem_min = 1'b1;
                state_next  = ST_YEAR;
            end
            ST_YEAR: begin
                if (status.year_done) begin
                    state_next = ST_MONTH;
                end else begin
                    cmd.year_step = 1'b1;
                end
            end
            ST_MONTH: begin
                if (!status.month_done) begin
                    cmd.month_step = 1'b1;
                end else if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;

endmodule

@@ verif/tb_unix_seconds_to_calendar.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_unix_seconds_to_calendar
// Self-checking bench for the unix seconds to calendar converter. Each
// accepted word is converted by an independent year and month walk, and the
// expected breakdown is queued. Results are compared field by field in
// order. Stimulus starts with epoch, leap, century and range-end cases, then
// moves to random times. Both sides idle at random, with one long output
// stall that fills the block and backs up its input.
// ----------------------------------------------------------------------------
module tb_unix_seconds_to_calendar;

    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int unsigned RANDOM_PER_PHASE = 195;
    localparam int unsigned HOLD_OFF_CYCLES  = 400;
    localparam int unsigned SETTLE_CYCLES    = 250;

    localparam logic [31:0] DIRECTED_SECONDS [24] = '{
        32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
        32'd31535999, 32'd31536000, 32'd68169600, 32'd94694399,
        32'd951782400, 32'd978307199, 32'd2147483647, 32'd2147483648,
        32'd4107542399, 32'd4107542400, 32'd4291747199, 32'd4291747200,
        32'hAAAAAAAA, 32'h55555555, 32'hFFFFFFFE, 32'hFFFFFFFF
    };

    class calendar_scoreboard;
        usc_pkg::result_t pending_dates[$];
        int unsigned      mismatches = 0;

        function usc_pkg::result_t calendar_of(logic [31:0] secs);
            usc_pkg::result_t r;
            int unsigned t;
            int unsigned yr;
            int unsigned mon;
            int unsigned ylen;
            int unsigned mlen;
            bit          leap;
            t        = secs;
            r.second = 6'(t % 60);
            t        = t / 60;
            r.minute = 6'(t % 60);
            t        = t / 60;
            r.hour   = 5'(t % 24);
            t        = t / 24;
            r.weekday = 3'(((t + 4) % 7) + 1);
            yr = 1970;
            forever begin
                leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
                ylen = leap ? 366 : 365;
                if (t < ylen) break;
                t  -= ylen;
                yr += 1;
            end
            mon = 0;
            forever begin
                mlen = (mon == 1 && leap) ? 29 : MONTH_DAYS[mon];
                if (mon == 11 || t < mlen) break;
                t   -= mlen;
                mon += 1;
            end
            r.year         = 12'(yr);
            r.month        = 4'(mon);
            r.day_of_month = 5'(t + 1);
            return r;
        endfunction

        function void note_seconds(logic [31:0] secs);
            pending_dates.push_back(calendar_of(secs));
        endfunction

        function int unsigned pending_count();
            return pending_dates.size();
        endfunction

        function void check_calendar(logic [47:0] word);
            usc_pkg::result_t got;
            usc_pkg::result_t exp_date;
            if (pending_dates.size() == 0) begin
                $error("result word 0x%012h with no conversion pending", word);
                mismatches++;
                return;
            end
            exp_date = pending_dates.pop_front();
            got      = word[40:0];
            if (got.second != exp_date.second) begin
                $error("second: expected %0d, got %0d", exp_date.second, got.second);
                mismatches++;
            end
            if (got.minute != exp_date.minute) begin
                $error("minute: expected %0d, got %0d", exp_date.minute, got.minute);
                mismatches++;
            end
            if (got.hour != exp_date.hour) begin
                $error("hour: expected %0d, got %0d", exp_date.hour, got.hour);
                mismatches++;
            end
            if (got.weekday != exp_date.weekday) begin
                $error("weekday: expected %0d, got %0d", exp_date.weekday, got.weekday);
                mismatches++;
            end
            if (got.year != exp_date.year) begin
                $error("year: expected %0d, got %0d", exp_date.year, got.year);
                mismatches++;
            end
            if (got.month != exp_date.month) begin
                $error("month: expected %0d, got %0d", exp_date.month, got.month);
                mismatches++;
            end
            if (got.day_of_month != exp_date.day_of_month) begin
                $error("day_of_month: expected %0d, got %0d",
                       exp_date.day_of_month, got.day_of_month);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_cycles   = 0;

    calendar_scoreboard board = new();

    unix_seconds_to_calendar uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // offers one word, returns at the edge that accepts it with valid still high
    task automatic send_seconds(input logic [31:0] secs);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= secs;
        do @(posedge aclk); while (!s_tready);
        board.note_seconds(secs);
    endtask

    task automatic wait_all_done();
        s_tvalid <= 1'b0;
        while (board.pending_count() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] random_seconds();
        logic [63:0] day_start;
        logic [31:0] sod;
        case ($urandom_range(2))
            0: return $urandom;
            1: begin
                // day boundaries land on month and year ends
                day_start = 64'($urandom_range(49709)) * 64'd86400;
                case ($urandom_range(2))
                    0: sod = 32'd0;
                    1: sod = 32'd86399;
                    default: sod = $urandom_range(86399);
                endcase
                return 32'(day_start + 64'(sod));
            end
            default: return $urandom_range(32'd200000000);
        endcase
    endfunction

    // receiver side, including the long hold-off
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) board.check_calendar(m_tdata);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED_SECONDS[i]) send_seconds(DIRECTED_SECONDS[i]);
        wait_all_done();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 14;
                    recv_idle_pct = 56;
                    hold_cycles   = HOLD_OFF_CYCLES;
                end
                1: begin
                    send_idle_pct = 56;
                    recv_idle_pct = 14;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int i = 0; i < RANDOM_PER_PHASE; i++) send_seconds(random_seconds());
            wait_all_done();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (board.mismatches == 0 && board.pending_count() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
